// ----- src/gblur_pkg.sv -----
// ----------------------------------------------------------------------------
// gblur_pkg
// Shared types and constants for the 3x3 gaussian blur stream block.
// ----------------------------------------------------------------------------
`default_nettype none

package gblur_pkg;

  // payload and register widths
  localparam int PIX_W = 8;
  localparam int FW_W  = 11;
  localparam int FH_W  = 12;
  localparam int CFG_W = 12;
  localparam int ROW_W = 12;
  localparam int SUM_W = 12;

  // row buffer word: upper row in the high byte, middle row in the low byte
  localparam int LB_W = 2 * PIX_W;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // reset value of both frame dimensions
  localparam int DIM_RST = 1024;

endpackage

`default_nettype wire

// ----- src/gblur_ram.sv -----
// ----------------------------------------------------------------------------
// gblur_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gblur_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/gaussian_blur_3x3_stream.sv -----
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream
// 3x3 gaussian blur (1-2-1 kernel, divide by 16) over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock and produces the blurred value of interior
// pixel (r-1,c-1) from the transaction that carries pixel (r,c); border
// pixels give no output and last_of_frame marks the final interior result.
// Sustained rate is one pixel per clock cycle unless the output stalls. A
// result passes through stage 1 and the output register: the row buffer RAM
// (both previous rows packed in one word at the column address) is read at
// the accepting edge, and when stage 1 advances the window shifts and the
// weighted sum goes into the output register. The RAM is read, and the
// updated word written back, once per pixel. The RAM needs no clearing, so
// the block is ready out of reset. Writing frame_width or frame_height
// restarts the frame at pixel (0,0); writes are meant only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_3x3_stream #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [gblur_pkg::CFG_W-1:0]   cfg_data,
  // pixel input
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [gblur_pkg::PIX_W-1:0]   pixel,
  // result output
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [gblur_pkg::PIX_W-1:0]   blurred,
  output logic                               last_of_frame
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int W_RST  = (gblur_pkg::DIM_RST < MAX_WIDTH) ? gblur_pkg::DIM_RST : MAX_WIDTH;
  localparam logic [CW-1:0] COL_LAST_RST = CW'(W_RST - 1);
  localparam logic [gblur_pkg::ROW_W-1:0] ROW_LAST_RST =
    gblur_pkg::ROW_W'(gblur_pkg::DIM_RST - 1);

  localparam int PW = gblur_pkg::PIX_W;

  // frame geometry, held as last column and last row
  logic [CW-1:0]                 col_last;
  logic [gblur_pkg::ROW_W-1:0]   row_last;
  logic [31:0]                   w_req;
  logic [CW-1:0]                 col_last_next;
  logic [gblur_pkg::FH_W-1:0]    h_req;
  logic [gblur_pkg::ROW_W-1:0]   row_last_next;

  // raster position of the next pixel
  logic [CW-1:0]                 col_count;
  logic [gblur_pkg::ROW_W-1:0]   row_count;

  // stage 1: pixel waiting for its row buffer word
  logic                          s1_valid;
  logic                          s1_emit;
  logic                          s1_last;
  logic [PW-1:0]                 s1_px;
  logic [CW-1:0]                 s1_col;

  // handshakes
  logic                          in_acc;
  logic                          out_free;
  logic                          s1_adv;

  // row buffer RAM
  logic [gblur_pkg::LB_W-1:0]    lb_rdata;
  logic [PW-1:0]                 lb_top;
  logic [PW-1:0]                 lb_mid;

  // 3x3 window, [row][col], col 2 is the newest
  logic [PW-1:0]                 win [3][3];
  logic [gblur_pkg::SUM_W-1:0]   sum;

  // clamp requested geometry
  always_comb begin
    w_req = 32'(cfg_data[gblur_pkg::FW_W-1:0]);
    if (w_req < 32'd3) begin
      col_last_next = CW'(2);
    end else if (w_req > 32'(MAX_WIDTH)) begin
      col_last_next = CW'(MAX_WIDTH - 1);
    end else begin
      col_last_next = CW'(w_req - 32'd1);
    end
    h_req = cfg_data[gblur_pkg::FH_W-1:0];
    if (h_req < gblur_pkg::FH_W'(3)) begin
      row_last_next = gblur_pkg::ROW_W'(2);
    end else begin
      row_last_next = gblur_pkg::ROW_W'(h_req - gblur_pkg::FH_W'(1));
    end
  end

  // handshake control
  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && (!s1_emit || out_free);
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // configuration registers and raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_last  <= COL_LAST_RST;
      row_last  <= ROW_LAST_RST;
      col_count <= '0;
      row_count <= '0;
    end else if (cfg_we) begin
      case (gblur_pkg::cfg_reg_t'(cfg_index))
        gblur_pkg::REG_FRAME_WIDTH: begin
          col_last <= col_last_next;
        end
        gblur_pkg::REG_FRAME_HEIGHT: begin
          row_last <= row_last_next;
        end
        default: begin
          col_last <= col_last;
        end
      endcase
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      if (col_count == col_last) begin
        col_count <= '0;
        if (row_count == row_last) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + gblur_pkg::ROW_W'(1);
        end
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px   <= pixel;
      s1_col  <= col_count;
      s1_emit <= (row_count >= gblur_pkg::ROW_W'(2)) && (col_count >= CW'(2));
      s1_last <= (row_count >= gblur_pkg::ROW_W'(2)) && (col_count >= CW'(2)) &&
                 (row_count == row_last) && (col_count == col_last);
    end
  end

  // row buffers: read at accept, shift rows and write back as stage 1 leaves
  gblur_ram #(
    .WIDTH (gblur_pkg::LB_W),
    .DEPTH (MAX_WIDTH)
  ) u_lb (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata ({lb_mid, s1_px}),
    .re    (in_acc),
    .raddr (col_count),
    .rdata (lb_rdata)
  );

  assign lb_top = lb_rdata[gblur_pkg::LB_W-1:PW];
  assign lb_mid = lb_rdata[PW-1:0];

  // weighted sum over the window after this shift
  always_comb begin
    sum = gblur_pkg::SUM_W'(win[0][1])
        + (gblur_pkg::SUM_W'(win[0][2]) << 1)
        + gblur_pkg::SUM_W'(lb_top)
        + (gblur_pkg::SUM_W'(win[1][1]) << 1)
        + (gblur_pkg::SUM_W'(win[1][2]) << 2)
        + (gblur_pkg::SUM_W'(lb_mid) << 1)
        + gblur_pkg::SUM_W'(win[2][1])
        + (gblur_pkg::SUM_W'(win[2][2]) << 1)
        + gblur_pkg::SUM_W'(s1_px);
  end

  // window shift
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= lb_top;
      win[1][2] <= lb_mid;
      win[2][2] <= s1_px;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      blurred       <= sum[gblur_pkg::SUM_W-1:4];
      last_of_frame <= s1_last;
    end
  end

endmodule

`default_nettype wire

// ----- src/gblur_checker.sv -----
// ----------------------------------------------------------------------------
// gblur_checker
// Port-level checks for the 3x3 gaussian blur stream block.
// ----------------------------------------------------------------------------
`default_nettype none

module gblur_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [gblur_pkg::PIX_W-1:0] blurred,
  input wire logic                        last_of_frame
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(blurred) && $stable(last_of_frame))
    else $error("stalled result changed");

  // input is only held back by a full, stalled output register
  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output side is free");

  // nothing is shown or held back right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // an input and an output register that both stay idle drain the block
  a_drain: assert property (@(posedge clk) disable iff (rst)
    !in_valid && !out_valid ##1 !in_valid && !out_valid |=> !out_valid)
    else $error("result appeared without a recent pixel");

endmodule

bind gaussian_blur_3x3_stream gblur_checker u_gblur_checker (.*);

`default_nettype wire
